FILE: rtl/bbe_pkg.sv
package bbe_pkg;

  // Field widths fixed by the item format
  localparam int DEG_W      = 4;
  localparam int CELL_IDX_W = 5;
  localparam int NUM_N      = 1 << DEG_W;
  // C(15,7) = 6435 is the largest coefficient a 4-bit degree can reach
  localparam int BINOM_W    = 13;

  typedef logic [DEG_W-1:0] deg_t;

  // Control that travels alongside each item through the chain
  typedef struct packed {
    logic valid;
    deg_t degree;
    deg_t basis_index;
    logic index_error;
  } bbe_ctl_t;

  typedef logic [NUM_N-1:0][NUM_N-1:0][BINOM_W-1:0] binom_tab_t;

  // Build Pascal's triangle; entries with k above n stay zero
  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int n = 0; n < NUM_N; n++) begin
      tab[n][0] = BINOM_W'(1);
      for (int k = 1; k <= n; k++) begin
        tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = build_binom();

endpackage

FILE: rtl/bbe_if.sv
interface bbe_in_if #(
  parameter int FRAC_BITS = 16
);
  import bbe_pkg::*;

  logic                 valid;
  logic                 ready;
  deg_t                 degree;
  deg_t                 basis_index;
  logic [FRAC_BITS:0]   position;

  modport source (output valid, output degree, output basis_index, output position,
                  input ready);
  modport sink   (input valid, input degree, input basis_index, input position,
                  output ready);
endinterface

interface bbe_out_if #(
  parameter int FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   basis_value;
  logic                 index_error;

  modport source (output valid, output basis_value, output index_error, input ready);
  modport sink   (input valid, input basis_value, input index_error, output ready);
endinterface

FILE: rtl/bbe_cell.sv
module bbe_cell
  import bbe_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CELL_IDX  = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  bbe_ctl_t           ctl_i,
  input  logic [FRAC_BITS:0] pos_i,
  input  logic [FRAC_BITS:0] acc_i,
  output bbe_ctl_t           ctl_o,
  output logic [FRAC_BITS:0] pos_o,
  output logic [FRAC_BITS:0] acc_o
);

  localparam logic [CELL_IDX_W-1:0] IDX = CELL_IDX_W'(CELL_IDX);
  localparam logic [FRAC_BITS:0]    ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  bbe_ctl_t               ctl_r;
  logic [FRAC_BITS:0]     pos_r;
  logic [FRAC_BITS:0]     acc_r;
  logic [FRAC_BITS:0]     acc_nxt;
  logic [FRAC_BITS:0]     factor;
  logic [2*FRAC_BITS+1:0] prod;
  logic                   use_u;
  logic                   active;

  // Pick u for the first k steps, 1-u for the next n-k, pass beyond n
  always_comb begin
    use_u   = {1'b0, ctl_i.basis_index} > IDX;
    active  = {1'b0, ctl_i.degree} > IDX;
    factor  = use_u ? pos_i : (ONE - pos_i);
    prod    = acc_i * factor;
    acc_nxt = active ? prod[2*FRAC_BITS:FRAC_BITS] : acc_i;
  end

  // Advance control and payload to the neighbour; only the valid flag needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (advance) begin
      ctl_r.valid <= ctl_i.valid;
    end
    if (advance) begin
      ctl_r.degree      <= ctl_i.degree;
      ctl_r.basis_index <= ctl_i.basis_index;
      ctl_r.index_error <= ctl_i.index_error;
      pos_r             <= pos_i;
      acc_r             <= acc_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign pos_o = pos_r;
  assign acc_o = acc_r;

endmodule

FILE: rtl/bbe_binom.sv
module bbe_binom
  import bbe_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  bbe_ctl_t           ctl_i,
  input  logic [FRAC_BITS:0] acc_i,
  output logic               out_valid,
  output logic [FRAC_BITS:0] out_value,
  output logic               out_error
);

  localparam int PROD_W = FRAC_BITS + 1 + BINOM_W;
  localparam logic [PROD_W-1:0] ONE_P = PROD_W'(1) << FRAC_BITS;

  logic               valid_r;
  logic               err_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic               out_valid_r;
  logic               out_err_r;
  logic [FRAC_BITS:0] out_value_r;
  logic [FRAC_BITS:0] value_nxt;

  // Scale by the coefficient; a bad index reads zero from the table
  always_comb begin
    prod_nxt = acc_i * BINOM_TAB[ctl_i.degree][ctl_i.basis_index];
    if (prod_r > ONE_P) begin
      value_nxt = ONE_P[FRAC_BITS:0];
    end else begin
      value_nxt = prod_r[FRAC_BITS:0];
    end
    if (err_r) begin
      value_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      valid_r     <= ctl_i.valid;
      out_valid_r <= valid_r;
    end
  end

  // Register the product, then the saturated result
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r      <= prod_nxt;
      err_r       <= ctl_i.index_error;
      out_value_r <= value_nxt;
      out_err_r   <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_err_r;

endmodule

FILE: rtl/bernstein_basis_eval.sv
// Bernstein basis evaluator: each item (degree n, index k, position u in unsigned
// Q1.FRAC_BITS) returns one value C(n,k)*u^k*(1-u)^(n-k), truncated after every
// product and saturated at 1.0; an index above the degree returns 0 with
// index_error set. Degree saturates to MAX_DEGREE and position to 1.0 on entry.
// It takes one item per cycle unless the output is held; each result goes through
// MAX_DEGREE+3 register stages: one input stage, a chain of MAX_DEGREE cells with
// one multiplier each, a coefficient multiply stage and the output register. When
// the output is held the whole chain stalls and in_ch.ready drops with it.
module bernstein_basis_eval
  import bbe_pkg::*;
#(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  bbe_in_if.sink   in_ch,
  bbe_out_if.source out_ch
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic               advance;
  bbe_ctl_t           ctl_w [0:MAX_DEGREE];
  logic [FRAC_BITS:0] pos_w [0:MAX_DEGREE];
  logic [FRAC_BITS:0] acc_w [0:MAX_DEGREE];

  bbe_ctl_t           head_ctl_r;
  logic [FRAC_BITS:0] head_pos_r;
  deg_t               deg_sat;
  logic [FRAC_BITS:0] pos_sat;
  logic               out_valid;

  // Stall everything while a result waits at the output
  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance;

  // Clamp degree and position before any use
  always_comb begin
    if ({1'b0, in_ch.degree} > CELL_IDX_W'(MAX_DEGREE)) begin
      deg_sat = DEG_W'(MAX_DEGREE);
    end else begin
      deg_sat = in_ch.degree;
    end
    if (in_ch.position > ONE) begin
      pos_sat = ONE;
    end else begin
      pos_sat = in_ch.position;
    end
  end

  // Take the item into the input stage; only the valid flag needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ctl_r.valid <= 1'b0;
    end else if (advance) begin
      head_ctl_r.valid <= in_ch.valid;
    end
    if (advance) begin
      head_ctl_r.degree      <= deg_sat;
      head_ctl_r.basis_index <= in_ch.basis_index;
      head_ctl_r.index_error <= in_ch.basis_index > deg_sat;
      head_pos_r             <= pos_sat;
    end
  end

  assign ctl_w[0] = head_ctl_r;
  assign pos_w[0] = head_pos_r;
  assign acc_w[0] = ONE;

  // Chain of multiply cells, one step of the power product each
  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
    bbe_cell #(
      .FRAC_BITS (FRAC_BITS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .ctl_i   (ctl_w[i]),
      .pos_i   (pos_w[i]),
      .acc_i   (acc_w[i]),
      .ctl_o   (ctl_w[i+1]),
      .pos_o   (pos_w[i+1]),
      .acc_o   (acc_w[i+1])
    );
  end

  bbe_binom #(
    .FRAC_BITS (FRAC_BITS)
  ) u_binom (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .ctl_i     (ctl_w[MAX_DEGREE]),
    .acc_i     (acc_w[MAX_DEGREE]),
    .out_valid (out_valid),
    .out_value (out_ch.basis_value),
    .out_error (out_ch.index_error)
  );

  assign out_ch.valid = out_valid;

  // A bad index always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ch.index_error |-> out_ch.basis_value == '0)
    else $error("index error with non-zero value");

  // Results never exceed 1.0
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ch.basis_value <= ONE)
    else $error("basis value above one");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

FILE: tb/sv/testbench.sv
module testbench
  import bbe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEGREE = 15;
  localparam int FRAC_BITS  = 16;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int POS_MAX    = (1 << (FRAC_BITS + 1)) - 1;
  localparam int LATENCY    = MAX_DEGREE + 3;
  localparam int LONG_HOLD  = 80;

  typedef logic [FRAC_BITS:0] pos_t;

  typedef struct packed {
    pos_t basis_value;
    logic index_error;
  } basis_result_t;

  // Predict each accepted item and compare results against the oldest prediction
  class basis_scoreboard;
    basis_result_t expected_values[$];
    int            mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Binomial coefficient, one row step at a time
    function longint unsigned binomial(longint unsigned n, longint unsigned k);
      longint unsigned c;
      c = 1;
      for (longint unsigned i = 1; i <= k; i++) begin
        c = c * (n - k + i) / i;
      end
      return c;
    endfunction

    function basis_result_t predict_basis(deg_t deg_in, deg_t idx_in, pos_t pos_in);
      longint unsigned n, k, u, acc;
      basis_result_t   r;
      n = deg_in;
      k = idx_in;
      u = pos_in;
      if (n > MAX_DEGREE) n = MAX_DEGREE;
      if (u > ONE) u = ONE;
      // Index above degree gives zero and flags the error
      if (k > n) begin
        r.basis_value = '0;
        r.index_error = 1'b1;
        return r;
      end
      // Truncate after every product, u first, then (1 - u)
      acc = ONE;
      for (longint unsigned i = 0; i < k; i++) begin
        acc = (acc * u) >> FRAC_BITS;
      end
      for (longint unsigned i = 0; i < n - k; i++) begin
        acc = (acc * (ONE - u)) >> FRAC_BITS;
      end
      acc = acc * binomial(n, k);
      if (acc > ONE) acc = ONE;
      r.basis_value = acc[FRAC_BITS:0];
      r.index_error = 1'b0;
      return r;
    endfunction

    function void note_item(deg_t deg_in, deg_t idx_in, pos_t pos_in);
      expected_values.push_back(predict_basis(deg_in, idx_in, pos_in));
    endfunction

    function void check_item(pos_t value, logic err);
      basis_result_t e;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d error %0b",
                 $time, value, err);
        mismatch_count++;
        return;
      end
      e = expected_values.pop_front();
      if (value !== e.basis_value) begin
        $display("%0t: basis_value expected %0d actual %0d", $time, e.basis_value, value);
        mismatch_count++;
      end
      if (err !== e.index_error) begin
        $display("%0t: index_error expected %0b actual %0b", $time, e.index_error, err);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bbe_in_if  #(.FRAC_BITS(FRAC_BITS)) in_ch ();
  bbe_out_if #(.FRAC_BITS(FRAC_BITS)) out_ch ();

  bernstein_basis_eval #(
    .MAX_DEGREE(MAX_DEGREE),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  basis_scoreboard sb = new();

  int send_idle_pct = 25;
  int recv_idle_pct = 85;
  int hold_requests = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item, idling at random first, and note it once taken
  task automatic send_item(deg_t deg_in, deg_t idx_in, pos_t pos_in);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.degree      <= deg_in;
    in_ch.basis_index <= idx_in;
    in_ch.position    <= pos_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(deg_in, idx_in, pos_in);
  endtask

  // Mostly well-formed items near the peak of the basis, some extremes and noise
  task automatic send_random();
    int   mode;
    int   centre;
    deg_t n;
    deg_t k;
    pos_t u;
    mode = $urandom_range(0, 9);
    n    = deg_t'($urandom_range(0, 15));
    k    = deg_t'($urandom_range(0, n));
    if (mode == 0) begin
      k = deg_t'($urandom_range(0, 15));
      u = pos_t'($urandom_range(0, POS_MAX));
    end else if (mode == 1) begin
      case ($urandom_range(0, 3))
        0:       u = '0;
        1:       u = pos_t'(ONE);
        2:       u = pos_t'(ONE - 1);
        default: u = pos_t'($urandom_range(ONE + 1, POS_MAX));
      endcase
    end else begin
      if (n == 0) centre = $urandom_range(0, ONE);
      else        centre = (int'(k) * ONE) / int'(n);
      centre = centre + $urandom_range(0, 16384) - 8192;
      if (centre < 0)   centre = 0;
      if (centre > ONE) centre = ONE;
      u = pos_t'(centre);
    end
    send_item(n, k, u);
  endtask

  // Sample results, then choose the next ready, holding off when asked
  always @(posedge clk) begin : result_sink
    int hold_left;
    int seen_requests;
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_item(out_ch.basis_value, out_ch.index_error);
    if (seen_requests != hold_requests) begin
      seen_requests = hold_requests;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.degree      <= '0;
    in_ch.basis_index <= '0;
    in_ch.position    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, index above degree, position above one
    send_item(4'd0,  4'd0,  17'd0);
    send_item(4'd0,  4'd0,  17'd65536);
    send_item(4'd0,  4'd0,  17'h1FFFF);
    send_item(4'd15, 4'd0,  17'd0);
    send_item(4'd15, 4'd15, 17'd65536);
    send_item(4'd15, 4'd15, 17'd65535);
    send_item(4'd15, 4'd7,  17'd32768);
    send_item(4'd15, 4'd8,  17'd32768);
    send_item(4'd1,  4'd0,  17'd32768);
    send_item(4'd1,  4'd1,  17'd32768);
    send_item(4'd2,  4'd1,  17'd32768);
    send_item(4'd15, 4'd0,  17'd1);
    send_item(4'd15, 4'd15, 17'd1);
    send_item(4'd3,  4'd4,  17'd40000);
    send_item(4'd0,  4'd15, 17'd65536);
    send_item(4'd14, 4'd15, 17'h1FFFF);
    send_item(4'd15, 4'd15, 17'h1FFFF);
    send_item(4'd15, 4'd0,  17'd65537);
    send_item(4'd10, 4'd3,  17'd21845);
    send_item(4'd4,  4'd2,  17'd0);
    send_item(4'd4,  4'd2,  17'd65536);
    send_item(4'd7,  4'd3,  17'h15555);
    send_item(4'd15, 4'd1,  17'h0AAAA);
    send_item(4'd8,  4'd8,  17'h0FFFF);
    repeat (375) send_random();

    // Sender slow, receiver quick
    send_idle_pct = 85;
    recv_idle_pct = 25;
    repeat (375) send_random();

    // Neither side idles; a long hold on the output fills the chain first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (400) send_random();
    in_ch.valid <= 1'b0;

    // Drain, then allow time for any stray result
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
